// ----- src/ess_pkg.sv -----
// ess_pkg: shared types, constants and sequencer codes for the SCAN seek scheduler
// used by every module under src; no dependencies of its own

package ess_pkg;

  localparam int MAX_REQUESTS = 32;
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CYL_W = 16;
  localparam int TOTAL_W = 22;
  localparam int DCYL_W = 17;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // configuration register indexes
  localparam logic CFG_SWEEP_DOWN = 1'b0;
  localparam logic CFG_DISK_CYLINDERS = 1'b1;

  localparam logic [DCYL_W-1:0] DISK_CYLINDERS_RESET = 17'd5000;

  // input item kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RUN = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [CYL_W-1:0] cylinder;
  } in_item_t;

  typedef struct packed {
    logic [CYL_W-1:0]   position;
    logic [TOTAL_W-1:0] total_movement;
    logic               last;
    logic               rejected;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_END,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_END,
    PH_SECOND
  } phase_t;

  // operands of the shared compare unit
  typedef struct packed {
    logic [CYL_W-1:0] cand;
    logic [CYL_W-1:0] start;
    logic             want_upper;
    logic             visited;
    logic             best_found;
    logic [CYL_W-1:0] best_val;
  } sel_in_t;

endpackage

// ----- src/elevator_seek_scheduler_core.sv -----
// elevator_seek_scheduler_core: top level of the SCAN seek scheduler, holds the config registers
// depends on ess_pkg and ess_seq

// Loads (req_type 0) leave busy low; a load into a full store
// gives one rejected transaction on the next cycle. A run (req_type 1) raises busy and
// emits the SCAN visiting order, one transaction per selected cylinder, start head first.
// Each selection walks the whole store through one compare unit, one entry per cycle,
// so the length of a run is set by the single read port of the store. out_strobe is high
// for one cycle per transaction and the receiver cannot stall it. Write configuration
// only while busy is low.

module elevator_seek_scheduler_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  ess_pkg::in_item_t           in_item,
  output logic                        busy,
  output logic                        out_strobe,
  output ess_pkg::out_item_t          out_item,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [ess_pkg::DCYL_W-1:0]  cfg_wdata
);

  logic                       sweep_down_r;
  logic [ess_pkg::DCYL_W-1:0] disk_cyl_r;
  logic [ess_pkg::CYL_W-1:0]  top_cyl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_down_r <= 1'b0;
      disk_cyl_r <= ess_pkg::DISK_CYLINDERS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ess_pkg::CFG_SWEEP_DOWN: sweep_down_r <= cfg_wdata[0];
        ess_pkg::CFG_DISK_CYLINDERS: disk_cyl_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // top end is cylinders minus one, zero cylinders count as one, clipped to 16 bits
  always_comb begin
    if (disk_cyl_r == '0) begin
      top_cyl = '0;
    end else if (disk_cyl_r[ess_pkg::DCYL_W-1] && (disk_cyl_r[ess_pkg::DCYL_W-2:0] != '0)) begin
      top_cyl = '1;
    end else begin
      top_cyl = ess_pkg::CYL_W'(disk_cyl_r - ess_pkg::DCYL_W'(1));
    end
  end

  ess_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .busy       (busy),
    .sweep_down (sweep_down_r),
    .top_cyl    (top_cyl),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// ----- src/ess_store.sv -----
// ess_store: request cylinder store, one write and one registered read per cycle
// depends on ess_pkg for depth and widths

module ess_store (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ess_pkg::IDX_W-1:0] waddr,
  input  logic [ess_pkg::CYL_W-1:0] wdata,
  input  logic                      re,
  input  logic [ess_pkg::IDX_W-1:0] raddr,
  output logic [ess_pkg::CYL_W-1:0] rdata
);

  logic [ess_pkg::CYL_W-1:0] mem [ess_pkg::MAX_REQUESTS];
  logic [ess_pkg::CYL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/ess_select.sv -----
// ess_select: compare unit shared by every selection step of a run
// depends on ess_pkg for sel_in_t

module ess_select (
  input  ess_pkg::sel_in_t sel_in,
  output logic             take
);

  logic in_upper;
  logic in_set;
  logic better;

  always_comb begin
    in_upper = (sel_in.cand >= sel_in.start);
    in_set = (in_upper == sel_in.want_upper);
    // upper set climbs (smallest first), lower set descends (largest first)
    better = sel_in.want_upper ? (sel_in.cand < sel_in.best_val)
                               : (sel_in.cand > sel_in.best_val);
    take = !sel_in.visited && in_set && (!sel_in.best_found || better);
  end

endmodule

// ----- src/ess_seq.sv -----
// ess_seq: sequencer that walks the store once per selection step and builds results
// depends on ess_pkg, ess_store and ess_select

module ess_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  ess_pkg::in_item_t           in_item,
  output logic                        busy,
  input  logic                        sweep_down,
  input  logic [ess_pkg::CYL_W-1:0]   top_cyl,
  output logic                        out_strobe,
  output ess_pkg::out_item_t          out_item
);

  ess_pkg::state_t state_r, state_nxt;
  ess_pkg::phase_t phase_r, phase_nxt;

  logic [ess_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic [ess_pkg::CNT_W-1:0]        idx_r, idx_nxt;
  logic [ess_pkg::IDX_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic                             rd_valid_r, rd_valid_nxt;
  logic [ess_pkg::MAX_REQUESTS-1:0] visited_r, visited_nxt;
  logic                             best_found_r, best_found_nxt;
  logic [ess_pkg::CYL_W-1:0]        best_val_r, best_val_nxt;
  logic [ess_pkg::IDX_W-1:0]        best_idx_r, best_idx_nxt;
  logic [ess_pkg::CYL_W-1:0]        start_r, start_nxt;
  logic [ess_pkg::CYL_W-1:0]        head_r, head_nxt;
  logic [ess_pkg::TOTAL_W-1:0]      total_r, total_nxt;
  logic [ess_pkg::CYL_W-1:0]        pend_pos_r, pend_pos_nxt;
  logic [ess_pkg::TOTAL_W-1:0]      pend_total_r, pend_total_nxt;
  logic                             out_strobe_r, out_strobe_nxt;
  ess_pkg::out_item_t               out_item_r, out_item_nxt;

  logic                             mem_we;
  logic                             mem_re;
  logic [ess_pkg::CYL_W-1:0]        mem_rdata;
  ess_pkg::sel_in_t                 sel_in;
  logic                             take;

  logic                             emit;
  logic [ess_pkg::CYL_W-1:0]        emit_pos;
  logic [ess_pkg::CYL_W-1:0]        move;
  logic [ess_pkg::TOTAL_W:0]        sum;
  logic [ess_pkg::TOTAL_W-1:0]      new_total;
  logic [ess_pkg::CYL_W-1:0]        end_cyl;
  logic                             scan_done;
  logic                             accept;

  assign busy = (state_r != ess_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign scan_done = (idx_r == count_r) && !rd_valid_r;
  assign end_cyl = sweep_down ? '0 : top_cyl;

  ess_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[ess_pkg::IDX_W-1:0]),
    .wdata (in_item.cylinder),
    .re    (mem_re),
    .raddr (idx_r[ess_pkg::IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  always_comb begin
    sel_in.cand = mem_rdata;
    sel_in.start = start_r;
    sel_in.want_upper = (phase_r == ess_pkg::PH_FIRST) ? !sweep_down : sweep_down;
    sel_in.visited = visited_r[rd_idx_r];
    sel_in.best_found = best_found_r;
    sel_in.best_val = best_val_r;
  end

  ess_select u_select (
    .sel_in (sel_in),
    .take   (take)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ess_pkg::ST_IDLE: begin
        if (accept && in_item.req_type == ess_pkg::REQ_RUN) begin
          state_nxt = ess_pkg::ST_SCAN;
        end
      end
      ess_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ess_pkg::ST_PICK;
        end
      end
      ess_pkg::ST_PICK: begin
        if (best_found_r) begin
          state_nxt = ess_pkg::ST_SCAN;
        end else if (phase_r == ess_pkg::PH_FIRST) begin
          state_nxt = ess_pkg::ST_END;
        end else begin
          state_nxt = ess_pkg::ST_DONE;
        end
      end
      ess_pkg::ST_END: state_nxt = ess_pkg::ST_SCAN;
      ess_pkg::ST_DONE: state_nxt = ess_pkg::ST_IDLE;
      default: state_nxt = ess_pkg::ST_IDLE;
    endcase
  end

  // head movement and saturating total for the position being emitted
  always_comb begin
    move = (emit_pos >= head_r) ? (emit_pos - head_r) : (head_r - emit_pos);
    sum = {1'b0, total_r} + (ess_pkg::TOTAL_W + 1)'(move);
    new_total = (sum > {1'b0, ess_pkg::TOTAL_MAX}) ? ess_pkg::TOTAL_MAX
                                                    : sum[ess_pkg::TOTAL_W-1:0];
  end

  // datapath and outputs
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    idx_nxt = idx_r;
    rd_idx_nxt = rd_idx_r;
    rd_valid_nxt = 1'b0;
    visited_nxt = visited_r;
    best_found_nxt = best_found_r;
    best_val_nxt = best_val_r;
    best_idx_nxt = best_idx_r;
    start_nxt = start_r;
    head_nxt = head_r;
    total_nxt = total_r;
    pend_pos_nxt = pend_pos_r;
    pend_total_nxt = pend_total_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt = out_item_r;
    mem_we = 1'b0;
    mem_re = 1'b0;
    emit = 1'b0;
    emit_pos = '0;

    unique case (state_r)
      ess_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_item.req_type == ess_pkg::REQ_LOAD) begin
            if (count_r == ess_pkg::CNT_W'(ess_pkg::MAX_REQUESTS)) begin
              out_strobe_nxt = 1'b1;
              out_item_nxt.position = in_item.cylinder;
              out_item_nxt.total_movement = '0;
              out_item_nxt.last = 1'b0;
              out_item_nxt.rejected = 1'b1;
            end else begin
              mem_we = 1'b1;
              count_nxt = count_r + ess_pkg::CNT_W'(1);
            end
          end else begin
            // start head is the first result, held until the next one is known
            start_nxt = in_item.cylinder;
            head_nxt = in_item.cylinder;
            total_nxt = '0;
            pend_pos_nxt = in_item.cylinder;
            pend_total_nxt = '0;
            visited_nxt = '0;
            phase_nxt = ess_pkg::PH_FIRST;
            idx_nxt = '0;
            best_found_nxt = 1'b0;
          end
        end
      end
      ess_pkg::ST_SCAN: begin
        if (idx_r < count_r) begin
          mem_re = 1'b1;
          rd_valid_nxt = 1'b1;
          rd_idx_nxt = idx_r[ess_pkg::IDX_W-1:0];
          idx_nxt = idx_r + ess_pkg::CNT_W'(1);
        end
        if (rd_valid_r && take) begin
          best_found_nxt = 1'b1;
          best_val_nxt = mem_rdata;
          best_idx_nxt = rd_idx_r;
        end
      end
      ess_pkg::ST_PICK: begin
        if (best_found_r) begin
          emit = 1'b1;
          emit_pos = best_val_r;
          visited_nxt[best_idx_r] = 1'b1;
          idx_nxt = '0;
          best_found_nxt = 1'b0;
        end else if (phase_r == ess_pkg::PH_FIRST) begin
          phase_nxt = ess_pkg::PH_END;
        end
      end
      ess_pkg::ST_END: begin
        if (head_r != end_cyl) begin
          emit = 1'b1;
          emit_pos = end_cyl;
        end
        phase_nxt = ess_pkg::PH_SECOND;
        idx_nxt = '0;
        best_found_nxt = 1'b0;
      end
      ess_pkg::ST_DONE: begin
        out_strobe_nxt = 1'b1;
        out_item_nxt.position = pend_pos_r;
        out_item_nxt.total_movement = pend_total_r;
        out_item_nxt.last = 1'b1;
        out_item_nxt.rejected = 1'b0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase

    // a new position releases the held one as a non-final transaction
    if (emit) begin
      out_strobe_nxt = 1'b1;
      out_item_nxt.position = pend_pos_r;
      out_item_nxt.total_movement = pend_total_r;
      out_item_nxt.last = 1'b0;
      out_item_nxt.rejected = 1'b0;
      pend_pos_nxt = emit_pos;
      pend_total_nxt = new_total;
      head_nxt = emit_pos;
      total_nxt = new_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ess_pkg::ST_IDLE;
      phase_r <= ess_pkg::PH_FIRST;
      count_r <= '0;
      idx_r <= '0;
      rd_valid_r <= 1'b0;
      visited_r <= '0;
      best_found_r <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      idx_r <= idx_nxt;
      rd_valid_r <= rd_valid_nxt;
      visited_r <= visited_nxt;
      best_found_r <= best_found_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    best_val_r <= best_val_nxt;
    best_idx_r <= best_idx_nxt;
    start_r <= start_nxt;
    head_r <= head_nxt;
    total_r <= total_nxt;
    pend_pos_r <= pend_pos_nxt;
    pend_total_r <= pend_total_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item = out_item_r;

endmodule
